[hw/rtl/pidsg_pkg.sv]
// Package for the sample-gated PID controller: widths, config record,
// queue entry type, register indexes and the shared clamp function.
// No dependencies.
package pidsg_pkg;

    localparam int GAIN_FRAC_BITS = 8;
    localparam int DATA_W         = 16;
    localparam int EXT_W          = DATA_W + 1;
    localparam int TIME_W         = 32;
    localparam int PROD_W         = 2 * EXT_W;
    localparam int CALC_W         = PROD_W + 2;
    localparam int INTEG_W        = DATA_W + GAIN_FRAC_BITS;
    localparam int ROUND_HALF     = (1 << GAIN_FRAC_BITS) >> 1;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W      = 3;

    localparam logic [DATA_W-1:0]        PROP_GAIN_RST  = 16'd256;
    localparam logic signed [DATA_W-1:0] LOW_LIMIT_RST  = -16'sd255;
    localparam logic signed [DATA_W-1:0] HIGH_LIMIT_RST = 16'sd255;
    localparam logic [DATA_W-1:0]        PERIOD_RST     = 16'd50;
    localparam logic signed [DATA_W-1:0] DATA_MIN       = -16'sd32768;
    localparam logic signed [DATA_W-1:0] DATA_MAX       = 16'sd32767;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN   = 3'd0,
        CFG_INTEG_GAIN  = 3'd1,
        CFG_DERIV_GAIN  = 3'd2,
        CFG_LOW_LIMIT   = 3'd3,
        CFG_HIGH_LIMIT  = 3'd4,
        CFG_PERIOD      = 3'd5,
        CFG_AUTO_MODE   = 3'd6
    } t_cfg_reg;

    typedef logic signed [CALC_W-1:0] t_calc;

    typedef struct packed {
        logic [DATA_W-1:0]        prop_gain;
        logic [DATA_W-1:0]        integ_gain;
        logic [DATA_W-1:0]        deriv_gain;
        logic signed [DATA_W-1:0] low_limit;
        logic signed [DATA_W-1:0] high_limit;
        logic [DATA_W-1:0]        period;
        logic                     auto_mode;
    } t_cfg;

    // one classified sample waiting for the arithmetic
    typedef struct packed {
        logic                     manual;
        logic                     init;
        logic                     compute;
        logic                     direct;
        logic signed [PROD_W-1:0] pp;
        logic signed [PROD_W-1:0] pi;
        logic signed [PROD_W-1:0] pd;
    } t_item;

    typedef struct packed {
        logic manual;
        logic compute;
        logic direct;
    } t_flags;

    // upper bound tested first, so reversed limits give high or low
    function automatic t_calc clamp_q(t_calc x, t_calc lo, t_calc hi);
        t_calc r;
        if (x > hi) begin
            r = hi;
        end else if (x < lo) begin
            r = lo;
        end else begin
            r = x;
        end
        return r;
    endfunction

endpackage

[hw/rtl/pidsg_front.sv]
// Front end: classifies each accepted sample (manual, first auto, due),
// keeps the time and measurement history and forms the three gain products.
// Depends on pidsg_pkg.
module pidsg_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic signed [pidsg_pkg::DATA_W-1:0] i_target_value,
    input  logic signed [pidsg_pkg::DATA_W-1:0] i_measured_value,
    input  logic [pidsg_pkg::TIME_W-1:0]     i_now_ms,
    input  logic                             i_control_negative,
    input  pidsg_pkg::t_cfg                  i_cfg,
    output pidsg_pkg::t_item                 o_item
);
    import pidsg_pkg::*;

    logic                     r_was_auto, n_was_auto;
    logic signed [DATA_W-1:0] r_prev_meas, n_prev_meas;
    logic [TIME_W-1:0]        r_prev_time, n_prev_time;

    logic                     init;
    logic                     compute;
    logic signed [DATA_W-1:0] meas_ref;
    logic [TIME_W-1:0]        elapsed;
    logic signed [EXT_W-1:0]  err;
    logic signed [EXT_W-1:0]  dmeas;

    always_comb begin
        init     = i_cfg.auto_mode & ~r_was_auto;
        meas_ref = init ? i_measured_value : r_prev_meas;
        elapsed  = i_now_ms - r_prev_time;
        compute  = i_cfg.auto_mode & (elapsed >= TIME_W'(i_cfg.period));
        err      = EXT_W'(i_target_value) - EXT_W'(i_measured_value);
        dmeas    = EXT_W'(i_measured_value) - EXT_W'(meas_ref);

        o_item.manual  = ~i_cfg.auto_mode;
        o_item.init    = init;
        o_item.compute = compute;
        o_item.direct  = i_control_negative;
        o_item.pp      = $signed({1'b0, i_cfg.prop_gain}) * err;
        o_item.pi      = $signed({1'b0, i_cfg.integ_gain}) * err;
        o_item.pd      = $signed({1'b0, i_cfg.deriv_gain}) * dmeas;

        n_was_auto  = i_cfg.auto_mode;
        n_prev_meas = (compute | init) ? i_measured_value : r_prev_meas;
        n_prev_time = compute ? i_now_ms : r_prev_time;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_was_auto  <= 1'b0;
            r_prev_meas <= '0;
            r_prev_time <= '0;
        end else if (i_accept) begin
            r_was_auto  <= n_was_auto;
            r_prev_meas <= n_prev_meas;
            r_prev_time <= n_prev_time;
        end
    end

endmodule

[hw/rtl/pidsg_queue.sv]
// Short FIFO between the front end and the arithmetic back end.
// Depends on pidsg_pkg.
module pidsg_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pidsg_pkg::t_item i_item,
    input  logic             i_pop,
    output pidsg_pkg::t_item o_head,
    output logic             o_empty,
    output logic             o_full
);
    import pidsg_pkg::*;

    t_item               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]   r_count, n_count;

    always_comb begin
        o_head  = r_mem[r_rd_ptr];
        o_empty = (r_count == '0);
        o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));

        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

[hw/rtl/pidsg_back.sv]
// Back end: integral update, output sum, clamp and rounding, drive sign.
// Three stages plus the output register. Depends on pidsg_pkg.
module pidsg_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  pidsg_pkg::t_cfg                      i_cfg,
    input  pidsg_pkg::t_item                     i_head,
    input  logic                                 i_empty,
    output logic                                 o_pop,
    input  logic                                 i_out_stall,
    output logic                                 o_out_valid,
    output logic signed [pidsg_pkg::DATA_W-1:0]  o_drive_value,
    output logic                                 o_computed
);
    import pidsg_pkg::*;

    logic                      adv;
    t_calc                     lo_q, hi_q, clamp0;

    // stage 1
    logic                      r_s1_valid;
    t_item                     r_s1;
    logic signed [INTEG_W-1:0] r_integ, n_integ;
    t_calc                     base, pi_x, integ_sum, integ_new, ppd;

    // stage 2
    logic                      r_s2_valid;
    t_flags                    r_s2_flags;
    t_calc                     r_s2_ppd;
    logic signed [INTEG_W-1:0] r_s2_integ;

    // stage 3
    logic                      r_s3_valid;
    t_flags                    r_s3_flags;
    t_calc                     r_s3_o;
    t_calc                     o_cl, rounded;
    logic signed [DATA_W-1:0]  held_new, held_cur, drive;
    logic signed [DATA_W-1:0]  r_held;

    // output register
    logic                      r_out_valid;
    logic signed [DATA_W-1:0]  r_drive;
    logic                      r_computed;

    assign adv   = ~(r_out_valid & i_out_stall);
    assign o_pop = adv & ~i_empty;

    always_comb begin
        lo_q   = t_calc'(i_cfg.low_limit) <<< GAIN_FRAC_BITS;
        hi_q   = t_calc'(i_cfg.high_limit) <<< GAIN_FRAC_BITS;
        clamp0 = clamp_q('0, lo_q, hi_q);

        // integral: restarts from zero clamped to the limits when auto mode restarts
        base      = r_s1.init ? clamp0 : t_calc'(r_integ);
        pi_x      = t_calc'(r_s1.pi);
        integ_sum = r_s1.direct ? base + pi_x : base - pi_x;
        integ_new = clamp_q(integ_sum, lo_q, hi_q);
        ppd       = r_s1.direct ? t_calc'(r_s1.pp) - t_calc'(r_s1.pd)
                                : t_calc'(r_s1.pd) - t_calc'(r_s1.pp);

        n_integ = r_integ;
        if (r_s1_valid && !r_s1.manual) begin
            if (r_s1.compute) begin
                n_integ = integ_new[INTEG_W-1:0];
            end else if (r_s1.init) begin
                n_integ = clamp0[INTEG_W-1:0];
            end
        end

        // round half up is a floor after adding half an LSB
        o_cl     = clamp_q(r_s3_o, lo_q, hi_q);
        rounded  = (o_cl + t_calc'(ROUND_HALF)) >>> GAIN_FRAC_BITS;
        held_new = rounded[DATA_W-1:0];

        priority if (r_s3_flags.manual) begin
            held_cur = '0;
        end else if (r_s3_flags.compute) begin
            held_cur = held_new;
        end else begin
            held_cur = r_held;
        end

        if (r_s3_flags.direct) begin
            drive = held_cur;
        end else if (held_cur == DATA_MIN) begin
            drive = DATA_MAX;
        end else begin
            drive = -held_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_integ     <= '0;
            r_held      <= '0;
        end else if (adv) begin
            r_s1_valid  <= ~i_empty;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
            r_integ     <= n_integ;
            if (r_s3_valid) begin
                r_held <= held_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1               <= i_head;
            r_s2_flags.manual  <= r_s1.manual;
            r_s2_flags.compute <= r_s1.compute;
            r_s2_flags.direct  <= r_s1.direct;
            r_s2_ppd           <= ppd;
            r_s2_integ         <= integ_new[INTEG_W-1:0];
            r_s3_flags         <= r_s2_flags;
            r_s3_o             <= r_s2_ppd + t_calc'(r_s2_integ);
            r_drive            <= drive;
            r_computed         <= r_s3_flags.compute;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_drive_value = r_drive;
    assign o_computed    = r_computed;

endmodule

[hw/rtl/pid_sample_gated_controller.sv]
// Sample-gated PID controller, derivative on measurement.
// Input channel: i_in_valid / o_in_stall; a beat is taken when valid is high
// and stall low. Each beat carries setpoint, measurement, ms time and the
// direction flag, and yields exactly one result beat (drive, computed).
// Output channel: o_out_valid / i_out_stall; the result register holds its
// beat unchanged while stalled.
// Config channel: i_cfg_valid / o_cfg_ready (always ready), register index
// and 16-bit data; write only while no beats are in flight.
// Throughput: one beat per cycle while the output is not stalled and the
// queue not full. The front end classifies and multiplies in the accept
// cycle, a 4-deep queue decouples it from the back end, whose integral
// update feeds the integral register back on itself. A beat passes through
// the queue, stages 1 to 3 and the output register. A stalled output backs
// up the back end, then the queue; o_in_stall rises when the queue is full.
// Reset (synchronous, active low): config to its defaults, integral,
// history, held output and pipeline cleared; no beats pending.
// Depends on pidsg_pkg, pidsg_front, pidsg_queue, pidsg_back.
module pid_sample_gated_controller (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic signed [pidsg_pkg::DATA_W-1:0]     i_target_value,
    input  logic signed [pidsg_pkg::DATA_W-1:0]     i_measured_value,
    input  logic [pidsg_pkg::TIME_W-1:0]            i_now_ms,
    input  logic                                    i_control_negative,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [pidsg_pkg::DATA_W-1:0]     o_drive_value,
    output logic                                    o_computed,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [pidsg_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [pidsg_pkg::DATA_W-1:0]            i_cfg_data
);
    import pidsg_pkg::*;

    t_cfg  r_cfg;
    logic  accept;
    logic  q_full, q_empty, q_pop;
    t_item front_item, q_head;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid & ~q_full;
    assign o_in_stall  = q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain  <= PROP_GAIN_RST;
            r_cfg.integ_gain <= '0;
            r_cfg.deriv_gain <= '0;
            r_cfg.low_limit  <= LOW_LIMIT_RST;
            r_cfg.high_limit <= HIGH_LIMIT_RST;
            r_cfg.period     <= PERIOD_RST;
            r_cfg.auto_mode  <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_PROP_GAIN:  r_cfg.prop_gain  <= i_cfg_data;
                CFG_INTEG_GAIN: r_cfg.integ_gain <= i_cfg_data;
                CFG_DERIV_GAIN: r_cfg.deriv_gain <= i_cfg_data;
                CFG_LOW_LIMIT:  r_cfg.low_limit  <= $signed(i_cfg_data);
                CFG_HIGH_LIMIT: r_cfg.high_limit <= $signed(i_cfg_data);
                CFG_PERIOD:     r_cfg.period     <= i_cfg_data;
                CFG_AUTO_MODE:  r_cfg.auto_mode  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    pidsg_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (accept),
        .i_target_value     (i_target_value),
        .i_measured_value   (i_measured_value),
        .i_now_ms           (i_now_ms),
        .i_control_negative (i_control_negative),
        .i_cfg              (r_cfg),
        .o_item             (front_item)
    );

    pidsg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_item  (front_item),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    pidsg_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_head        (q_head),
        .i_empty       (q_empty),
        .o_pop         (q_pop),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_drive_value (o_drive_value),
        .o_computed    (o_computed)
    );

`ifndef SYNTH
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_manual_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !r_cfg.auto_mode |-> o_drive_value == '0 && !o_computed)
        else $error("manual mode result not zero");

    a_stall_only_when_backed_up: assert property (@(posedge i_clk)
        disable iff (!i_rst_n)
        o_in_stall |-> !q_empty)
        else $error("input stalled with an empty queue");
`endif

endmodule
